// ===== design/cfd_pkg.sv =====
// shared types and constants for the checksummed frame deframer
// used by every module of the block but cfd_ram; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

  localparam int MAX_LEN   = 64;
  localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W     = 7;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 32;
  localparam int NUM_ERR   = 3;
  localparam int ERR_AW    = (NUM_ERR > 1) ? $clog2(NUM_ERR) : 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0]    MAX_LEN_B     = BYTE_W'(MAX_LEN);
  localparam logic [BYTE_W-1:0]    SYNC_HDR_RST  = 8'd1;
  localparam logic [BYTE_W-1:0]    ASYNC_HDR_RST = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_HDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ASYNC_HDR = 2'd1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HDR_ERR = 2'd1,
    ST_LEN_ERR = 2'd2,
    ST_SUM_ERR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  // one completed frame or error, handed from the parser to the emitter
  typedef struct packed {
    logic             vld;
    status_t          status;
    logic             sync;
    logic [LEN_W-1:0] len;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } pay_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } pay_rd_t;

endpackage

`default_nettype wire

// ===== design/checksummed_frame_deframer.sv =====
// Checksummed frame deframer, top level.
// Input: one received serial word per in_valid/in_stall handshake on in_rx_byte.
// A frame is header, length (0 to 64), payload words, then the 8-bit sum of
// the payload. Header, length and payload words are taken one per cycle while
// in_stall is low. Results leave on the out_ channel through an output
// register. A good frame gives one result per payload word (out_last on the
// final one), an empty frame gives one result without data. A bad header,
// oversize length or checksum mismatch gives one error result carrying that
// kind's updated 32-bit wrapping counter, and parsing restarts at the header.
// After the closing word is taken, the run is registered, then a read step,
// then the first result is loaded into the output register. A good frame with
// payload is read from the payload ram one word per cycle unless out_stall
// holds; an error result does a read-modify-write of the counter
// ram. in_stall is high meanwhile, and stays high while out_stall pauses the
// readout. A result waiting in the output register does not stall the input.
// Config: cfg_index 0 sync header, 1 async header, others ignored; cfg_ready
// is always high. Reset (rst_n low, synchronous) restores headers 1 and 2,
// clears the parse state and counters; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module checksummed_frame_deframer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [cfd_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_status,
  output logic                               out_sync_frame,
  output logic [cfd_pkg::LEN_W-1:0]          out_frame_length,
  output logic [cfd_pkg::BYTE_W-1:0]         out_data_byte,
  output logic                               out_data_valid,
  output logic                               out_last,
  output logic [cfd_pkg::CNT_W-1:0]          out_error_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cfd_pkg::BYTE_W-1:0]    cfg_data
);

  logic [cfd_pkg::BYTE_W-1:0] sync_hdr_r;
  logic [cfd_pkg::BYTE_W-1:0] async_hdr_r;
  logic                       busy;
  cfd_pkg::job_t              job;
  cfd_pkg::pay_wr_t           pay_wr;
  cfd_pkg::pay_rd_t           pay_rd;
  logic [cfd_pkg::BYTE_W-1:0] pay_rd_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_hdr_r  <= cfd_pkg::SYNC_HDR_RST;
      async_hdr_r <= cfd_pkg::ASYNC_HDR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cfd_pkg::REG_SYNC_HDR:  sync_hdr_r  <= cfg_data;
        cfd_pkg::REG_ASYNC_HDR: async_hdr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .busy      (busy),
    .rx_byte   (in_rx_byte),
    .sync_hdr  (sync_hdr_r),
    .async_hdr (async_hdr_r),
    .job       (job),
    .pay_wr    (pay_wr)
  );

  // payload buffer, written by the parser, read back by the emitter
  cfd_ram #(
    .WIDTH (cfd_pkg::BYTE_W),
    .DEPTH (cfd_pkg::MAX_LEN)
  ) u_pay_ram (
    .clk     (clk),
    .wr_en   (pay_wr.en),
    .wr_addr (pay_wr.addr),
    .wr_data (pay_wr.data),
    .rd_en   (pay_rd.en),
    .rd_addr (pay_rd.addr),
    .rd_data (pay_rd_data)
  );

  cfd_emitter u_emitter (
    .clk              (clk),
    .rst_n            (rst_n),
    .job              (job),
    .busy             (busy),
    .pay_rd           (pay_rd),
    .pay_rd_data      (pay_rd_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_sync_frame   (out_sync_frame),
    .out_frame_length (out_frame_length),
    .out_data_byte    (out_data_byte),
    .out_data_valid   (out_data_valid),
    .out_last         (out_last),
    .out_error_count  (out_error_count)
  );

endmodule

`default_nettype wire

// ===== design/cfd_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module cfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/cfd_parser.sv =====
// frame parser: header, length and data phases; the checksum word closes the data phase
// writes the payload ram, hands finished frames and errors to the emitter; uses cfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module cfd_parser (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      busy,
  input  wire logic [cfd_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic [cfd_pkg::BYTE_W-1:0] sync_hdr,
  input  wire logic [cfd_pkg::BYTE_W-1:0] async_hdr,
  output cfd_pkg::job_t                  job,
  output cfd_pkg::pay_wr_t               pay_wr
);

  cfd_pkg::phase_t                phase_r, phase_nxt;
  logic                           is_sync_r, is_sync_nxt;
  logic [cfd_pkg::LEN_W-1:0]      exp_len_r, exp_len_nxt;
  logic [cfd_pkg::LEN_W-1:0]      idx_r, idx_nxt;
  logic [cfd_pkg::BYTE_W-1:0]     sum_r, sum_nxt;
  logic                           acc;

  assign acc = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= cfd_pkg::PH_HEADER;
      is_sync_r <= 1'b0;
      exp_len_r <= '0;
      idx_r     <= '0;
      sum_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      is_sync_r <= is_sync_nxt;
      exp_len_r <= exp_len_nxt;
      idx_r     <= idx_nxt;
      sum_r     <= sum_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    is_sync_nxt = is_sync_r;
    exp_len_nxt = exp_len_r;
    idx_nxt     = idx_r;
    sum_nxt     = sum_r;
    job         = '0;
    pay_wr.en   = 1'b0;
    pay_wr.addr = idx_r[cfd_pkg::IDX_W-1:0];
    pay_wr.data = rx_byte;

    case (phase_r)
      cfd_pkg::PH_LENGTH: begin
        if (acc) begin
          idx_nxt = '0;
          sum_nxt = '0;
          if (rx_byte > cfd_pkg::MAX_LEN_B) begin
            job.vld    = 1'b1;
            job.status = cfd_pkg::ST_LEN_ERR;
            job.sync   = is_sync_r;
            phase_nxt  = cfd_pkg::PH_HEADER;
          end else begin
            exp_len_nxt = rx_byte[cfd_pkg::LEN_W-1:0];
            phase_nxt   = cfd_pkg::PH_DATA;
          end
        end
      end
      cfd_pkg::PH_DATA: begin
        if (acc) begin
          if (idx_r >= exp_len_r) begin
            // checksum word closes the frame
            job.vld    = 1'b1;
            job.status = (sum_r != rx_byte) ? cfd_pkg::ST_SUM_ERR : cfd_pkg::ST_OK;
            job.sync   = is_sync_r;
            job.len    = exp_len_r;
            phase_nxt  = cfd_pkg::PH_HEADER;
            idx_nxt    = '0;
            sum_nxt    = '0;
          end else begin
            pay_wr.en = 1'b1;
            sum_nxt   = sum_r + rx_byte;
            idx_nxt   = idx_r + 1'b1;
          end
        end
      end
      default: begin
        if (acc) begin
          if (rx_byte == sync_hdr) begin
            is_sync_nxt = 1'b1;
            phase_nxt   = cfd_pkg::PH_LENGTH;
          end else if (rx_byte == async_hdr) begin
            is_sync_nxt = 1'b0;
            phase_nxt   = cfd_pkg::PH_LENGTH;
          end else begin
            job.vld    = 1'b1;
            job.status = cfd_pkg::ST_HDR_ERR;
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/cfd_emitter.sv =====
// result emitter: reads the payload ram out word by word, gives one result for an
// empty frame, or read-modify-writes an error counter in a small ram; uses cfd_pkg, cfd_ram
`timescale 1ns / 1ps
`default_nettype none

module cfd_emitter (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cfd_pkg::job_t              job,
  output logic                            busy,
  output cfd_pkg::pay_rd_t                pay_rd,
  input  wire logic [cfd_pkg::BYTE_W-1:0] pay_rd_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      out_status,
  output logic                            out_sync_frame,
  output logic [cfd_pkg::LEN_W-1:0]       out_frame_length,
  output logic [cfd_pkg::BYTE_W-1:0]      out_data_byte,
  output logic                            out_data_valid,
  output logic                            out_last,
  output logic [cfd_pkg::CNT_W-1:0]       out_error_count
);

  // run currently being emitted
  logic                          act_r, act_nxt;
  cfd_pkg::status_t              status_r, status_nxt;
  logic                          sync_r, sync_nxt;
  logic [cfd_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [cfd_pkg::LEN_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic [cfd_pkg::LEN_W-1:0]     rd_idx_inc;

  // read in flight / read data waiting for the output register
  logic                          pend_r, pend_nxt;
  logic                          pend_dv_r, pend_dv_nxt;
  logic                          pend_last_r, pend_last_nxt;

  logic [cfd_pkg::NUM_ERR-1:0]   cnt_vld_r, cnt_vld_nxt;
  logic [cfd_pkg::ERR_AW-1:0]    cnt_addr;
  logic                          cnt_rd_en;
  logic [cfd_pkg::CNT_W-1:0]     cnt_rd_data;
  logic [cfd_pkg::CNT_W-1:0]     cnt_cur;
  logic [cfd_pkg::CNT_W-1:0]     cnt_new;
  logic                          cnt_wr_en;
  logic                          is_err;

  logic                          load_now;
  logic                          can_issue;

  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_status_r;
  logic                          out_sync_r;
  logic [cfd_pkg::LEN_W-1:0]     out_len_r;
  logic [cfd_pkg::BYTE_W-1:0]    out_data_r;
  logic                          out_dv_r;
  logic                          out_last_r;
  logic [cfd_pkg::CNT_W-1:0]     out_cnt_r;

  cfd_ram #(
    .WIDTH (cfd_pkg::CNT_W),
    .DEPTH (cfd_pkg::NUM_ERR)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_addr),
    .wr_data (cnt_new),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_addr),
    .rd_data (cnt_rd_data)
  );

  assign is_err     = (status_r != cfd_pkg::ST_OK);
  assign cnt_addr   = cfd_pkg::ERR_AW'(status_r - 2'd1);
  // never-written counters read as zero
  assign cnt_cur    = cnt_vld_r[cnt_addr] ? cnt_rd_data : '0;
  assign cnt_new    = cnt_cur + 1'b1;
  assign rd_idx_inc = rd_idx_r + 1'b1;

  assign load_now  = pend_r && (!out_valid_r || !out_stall);
  assign can_issue = !pend_r || load_now;
  assign cnt_wr_en = load_now && is_err;
  assign busy      = act_r || pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      pend_r      <= 1'b0;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      pend_r      <= pend_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    sync_r      <= sync_nxt;
    len_r       <= len_nxt;
    rd_idx_r    <= rd_idx_nxt;
    pend_dv_r   <= pend_dv_nxt;
    pend_last_r <= pend_last_nxt;
    if (load_now) begin
      out_status_r <= status_r;
      out_sync_r   <= sync_r;
      out_len_r    <= len_r;
      out_data_r   <= pend_dv_r ? pay_rd_data : '0;
      out_dv_r     <= pend_dv_r;
      out_last_r   <= pend_last_r;
      out_cnt_r    <= is_err ? cnt_new : '0;
    end
  end

  always_comb begin
    act_nxt       = act_r;
    status_nxt    = status_r;
    sync_nxt      = sync_r;
    len_nxt       = len_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = pend_r;
    pend_dv_nxt   = pend_dv_r;
    pend_last_nxt = pend_last_r;
    cnt_rd_en     = 1'b0;
    pay_rd.en     = 1'b0;
    pay_rd.addr   = rd_idx_r[cfd_pkg::IDX_W-1:0];
    cnt_vld_nxt   = cnt_vld_r;

    if (load_now) begin
      pend_nxt = 1'b0;
    end
    if (cnt_wr_en) begin
      cnt_vld_nxt[cnt_addr] = 1'b1;
    end

    if (act_r && can_issue) begin
      pend_nxt = 1'b1;
      if (is_err) begin
        cnt_rd_en     = 1'b1;
        pend_dv_nxt   = 1'b0;
        pend_last_nxt = 1'b1;
        act_nxt       = 1'b0;
      end else if (len_r == '0) begin
        // empty good frame: one result without data
        pend_dv_nxt   = 1'b0;
        pend_last_nxt = 1'b1;
        act_nxt       = 1'b0;
      end else begin
        pay_rd.en     = 1'b1;
        pend_dv_nxt   = 1'b1;
        pend_last_nxt = (rd_idx_inc == len_r);
        rd_idx_nxt    = rd_idx_inc;
        act_nxt       = (rd_idx_inc != len_r);
      end
    end

    // a new run is only handed over while idle
    if (job.vld) begin
      act_nxt    = 1'b1;
      status_nxt = job.status;
      sync_nxt   = job.sync;
      len_nxt    = job.len;
      rd_idx_nxt = '0;
    end

    if (load_now) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_sync_frame   = out_sync_r;
  assign out_frame_length = out_len_r;
  assign out_data_byte    = out_data_r;
  assign out_data_valid   = out_dv_r;
  assign out_last         = out_last_r;
  assign out_error_count  = out_cnt_r;

endmodule

`default_nettype wire

// ===== tb/frame_checker.sv =====
// checker for the checksummed frame deframer: watches the in_, out_ and cfg_ channels,
// predicts every result word from the accepted input words and compares them in order
// depends on cfd_pkg for widths, status codes, parse phases and register indexes
`timescale 1ns / 1ps

module frame_checker
  import cfd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic [1:0]           out_status,
  input  wire logic                 out_sync_frame,
  input  wire logic [LEN_W-1:0]     out_frame_length,
  input  wire logic [BYTE_W-1:0]    out_data_byte,
  input  wire logic                 out_data_valid,
  input  wire logic                 out_last,
  input  wire logic [CNT_W-1:0]     out_error_count,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    status_t           status;
    logic              sync;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
    logic              data_valid;
    logic              last;
    logic [CNT_W-1:0]  count;
  } deframed_t;

  deframed_t result_q[$];

  // shadow of the parser
  logic [BYTE_W-1:0] sync_hdr;
  logic [BYTE_W-1:0] async_hdr;
  phase_t            phase;
  logic              frame_is_sync;
  logic [LEN_W-1:0]  frame_len;
  logic [LEN_W-1:0]  byte_idx;
  logic [BYTE_W-1:0] payload_sum;
  logic [BYTE_W-1:0] payload_mem [MAX_LEN];
  logic [CNT_W-1:0]  err_count [NUM_ERR];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic push_result(input status_t st, input logic sync, input logic [LEN_W-1:0] len,
                             input logic [BYTE_W-1:0] data, input logic dv, input logic last,
                             input logic [CNT_W-1:0] count);
    deframed_t r;
    r.status     = st;
    r.sync       = sync;
    r.len        = len;
    r.data       = data;
    r.data_valid = dv;
    r.last       = last;
    r.count      = count;
    result_q.insert(result_q.size(), r);
  endtask

  // counters are indexed header, length, checksum
  task automatic raise_error(input status_t st, input logic sync, input logic [LEN_W-1:0] len);
    int k;
    k = int'(st) - 1;
    err_count[k] = err_count[k] + 1'b1;
    phase        = PH_HEADER;
    byte_idx     = '0;
    payload_sum  = '0;
    push_result(st, sync, len, '0, 1'b0, 1'b1, err_count[k]);
  endtask

  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
    int k;
    case (phase)
      PH_LENGTH: begin
        if (b > MAX_LEN_B) begin
          raise_error(ST_LEN_ERR, frame_is_sync, '0);
        end else begin
          frame_len   = b[LEN_W-1:0];
          byte_idx    = '0;
          payload_sum = '0;
          phase       = PH_DATA;
        end
      end
      PH_DATA: begin
        if (byte_idx >= frame_len) begin
          // this word is the checksum
          if (payload_sum != b) begin
            raise_error(ST_SUM_ERR, frame_is_sync, frame_len);
          end else begin
            phase       = PH_HEADER;
            byte_idx    = '0;
            payload_sum = '0;
            if (frame_len == 0) begin
              push_result(ST_OK, frame_is_sync, '0, '0, 1'b0, 1'b1, '0);
            end else begin
              for (k = 0; k < int'(frame_len); k++)
                push_result(ST_OK, frame_is_sync, frame_len, payload_mem[k], 1'b1,
                            k == int'(frame_len) - 1, '0);
            end
          end
        end else begin
          payload_mem[byte_idx[IDX_W-1:0]] = b;
          payload_sum = payload_sum + b;
          byte_idx    = byte_idx + 1'b1;
        end
      end
      default: begin
        // sync wins when both header registers hold the same value
        if (b == sync_hdr) begin
          frame_is_sync = 1'b1;
          phase         = PH_LENGTH;
        end else if (b == async_hdr) begin
          frame_is_sync = 1'b0;
          phase         = PH_LENGTH;
        end else begin
          raise_error(ST_HDR_ERR, 1'b0, '0);
        end
      end
    endcase
  endtask

  task automatic check_result();
    deframed_t r;
    if (result_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result word, status %0d data %0h",
                                out_status, out_data_byte));
    end else begin
      r = result_q.pop_front();
      if (out_status !== r.status)
        report_mismatch($sformatf("status: expected %0d got %0d", r.status, out_status));
      if (out_sync_frame !== r.sync)
        report_mismatch($sformatf("sync_frame: expected %0b got %0b", r.sync, out_sync_frame));
      if (out_frame_length !== r.len)
        report_mismatch($sformatf("frame_length: expected %0d got %0d", r.len,
                                  out_frame_length));
      if (out_data_byte !== r.data)
        report_mismatch($sformatf("data_byte: expected %0h got %0h", r.data, out_data_byte));
      if (out_data_valid !== r.data_valid)
        report_mismatch($sformatf("data_valid: expected %0b got %0b", r.data_valid,
                                  out_data_valid));
      if (out_last !== r.last)
        report_mismatch($sformatf("last: expected %0b got %0b", r.last, out_last));
      if (out_error_count !== r.count)
        report_mismatch($sformatf("error_count: expected %0d got %0d", r.count,
                                  out_error_count));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sync_hdr      = SYNC_HDR_RST;
      async_hdr     = ASYNC_HDR_RST;
      phase         = PH_HEADER;
      frame_is_sync = 1'b0;
      frame_len     = '0;
      byte_idx      = '0;
      payload_sum   = '0;
      for (int k = 0; k < NUM_ERR; k++)
        err_count[k] = '0;
      result_q.delete();
    end else begin
      // results leave only after their input word has been taken, so check them first
      if (out_valid === 1'b1 && out_stall === 1'b0)
        check_result();
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        if (cfg_index == REG_SYNC_HDR)
          sync_hdr = cfg_data;
        else if (cfg_index == REG_ASYNC_HDR)
          async_hdr = cfg_data;
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        parse_rx_byte(in_rx_byte);
    end
    pending = result_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// top of the deframer testbench: clock, reset, header register writes and word stimulus
// depends on cfd_pkg, checksummed_frame_deframer and frame_checker (which does all checking)
`timescale 1ns / 1ps

module testbench;
  import cfd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int QUIET_LIMIT = 4000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_stall  = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_SYNC_HDR;
  logic [BYTE_W-1:0]    cfg_data   = '0;

  logic                 in_stall;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic                 out_sync_frame;
  logic [LEN_W-1:0]     out_frame_length;
  logic [BYTE_W-1:0]    out_data_byte;
  logic                 out_data_valid;
  logic                 out_last;
  logic [CNT_W-1:0]     out_error_count;
  logic                 cfg_ready;

  int fail_count;
  int pending;
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int sent_bytes    = 0;
  int quiet_cycles  = 0;
  logic [BYTE_W-1:0] sync_hdr_now  = SYNC_HDR_RST;
  logic [BYTE_W-1:0] async_hdr_now = ASYNC_HDR_RST;

  checksummed_frame_deframer dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_rx_byte,
    .out_valid, .out_stall, .out_status, .out_sync_frame, .out_frame_length,
    .out_data_byte, .out_data_valid, .out_last, .out_error_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  frame_checker frame_chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_rx_byte,
    .out_valid, .out_stall, .out_status, .out_sync_frame, .out_frame_length,
    .out_data_byte, .out_data_valid, .out_last, .out_error_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0) ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent_bytes++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_headers(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] a);
    write_reg(REG_SYNC_HDR, s);
    write_reg(REG_ASYNC_HDR, a);
    sync_hdr_now  = s;
    async_hdr_now = a;
  endtask

  // drop valid, wait for every predicted word, then give the parser time to go quiet
  task automatic drain(input int tail);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  // mostly well-formed frames; some bad sums, oversize lengths and stray words
  task automatic send_frame(input int fixed_len);
    int pick;
    int len;
    int k;
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    pick = $urandom_range(99);
    hdr  = $urandom_range(1) ? sync_hdr_now : async_hdr_now;
    if (fixed_len < 0 && pick < 8) begin
      send_byte(8'($urandom));
    end else if (fixed_len < 0 && pick < 16) begin
      send_byte(hdr);
      send_byte(8'($urandom_range(255, 65)));
    end else begin
      if (fixed_len >= 0)
        len = fixed_len;
      else if ($urandom_range(19) == 0)
        len = $urandom_range(MAX_LEN, 33);
      else
        len = $urandom_range(8);
      send_byte(hdr);
      send_byte(8'(len));
      sum = '0;
      for (k = 0; k < len; k++) begin
        b   = 8'($urandom);
        sum = sum + b;
        send_byte(b);
      end
      if (pick < 30)
        sum = sum ^ 8'($urandom_range(255, 1));
      send_byte(sum);
    end
  endtask

  task automatic run_frames(input int budget, input int first_len);
    int start;
    start = sent_bytes;
    if (first_len >= 0)
      send_frame(first_len);
    while (sent_bytes - start < budget)
      send_frame(-1);
  endtask

  initial begin
    in_gap_pct    = 25;
    out_stall_pct = 65;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset headers: 1 sync, 2 async
    send_byte(8'h00);                                  // bad header, lowest value
    send_byte(8'hFF);                                  // bad header, highest value
    send_byte(8'h01); send_byte(8'h00); send_byte(8'h00);            // empty sync frame
    send_byte(8'h02); send_byte(8'h01); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'h01); send_byte(8'h41);                // length one past the limit
    send_byte(8'h02); send_byte(8'hFF);                // largest length word
    send_byte(8'h02); send_byte(8'h02); send_byte(8'h80); send_byte(8'h80);
    send_byte(8'h01);                                  // sum wraps to zero, so this fails
    send_byte(8'h01); send_byte(8'h02); send_byte(8'h00); send_byte(8'hAA);
    send_byte(8'hAA);
    send_byte(8'h02); send_byte(8'h00); send_byte(8'h07);            // empty frame, bad sum
    drain(10);

    set_headers(8'h00, 8'hFF);
    write_reg(REG_SPARE_LO, 8'($urandom));
    write_reg(REG_SPARE_HI, 8'($urandom));
    run_frames(70, MAX_LEN);
    drain(10);

    in_gap_pct    = 65;
    out_stall_pct = 25;
    set_headers(8'hA5, 8'hA5);                         // same value: sync must win
    run_frames(40, -1);
    drain(10);

    in_gap_pct    = 0;
    out_stall_pct = 0;
    set_headers(8'hFF, 8'h00);
    run_frames(40, -1);
    drain(20);

    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
